### sv/afe_pkg.sv
// ----------------------------------------------------------------------------
// API frame encoder package
// Shared types and constants for the frame encoder front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package afe_pkg;

  localparam logic [7:0]  DELIM_BYTE  = 8'h7E;
  localparam logic [7:0]  CSUM_BASE   = 8'hFF;
  localparam logic [15:0] MAX_PAYLOAD = 16'd65533;
  localparam int          QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] payload_length;
    logic [7:0]  frame_type;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_t;

  // One classified input word, ready for serialization.
  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  data;
    logic [15:0] flen;
    logic [7:0]  ftype;
    logic [7:0]  id;
    logic [7:0]  csum;
  } cmd_t;

endpackage

`default_nettype wire

### sv/afe_fifo.sv
// ----------------------------------------------------------------------------
// API frame encoder command queue
// Small register queue between the classifying front and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module afe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = afe_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### sv/afe_front.sv
// ----------------------------------------------------------------------------
// API frame encoder front
// Accepts payload bytes, tracks frame state and builds one command per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module afe_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  wire afe_pkg::in_t  in_data,
  input  wire logic          q_full,
  output logic               q_push,
  output afe_pkg::cmd_t      q_cmd
);

  logic [7:0]  frame_counter_r, frame_counter_nxt;
  logic [15:0] bytes_remaining_r, bytes_remaining_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;

  logic        open_frame;
  logic [15:0] plen;
  logic [15:0] rem_base;
  logic [7:0]  sum_base;
  logic [7:0]  sum_new;

  assign q_push     = in_push && !q_full;
  assign open_frame = (bytes_remaining_r != '0);

  always_comb begin
    plen = in_data.payload_length;
    if (plen == '0) begin
      plen = 16'd1;
    end else if (plen > afe_pkg::MAX_PAYLOAD) begin
      plen = afe_pkg::MAX_PAYLOAD;
    end

    rem_base = open_frame ? bytes_remaining_r : plen;
    sum_base = open_frame ? running_sum_r : in_data.frame_type + frame_counter_r;
    sum_new  = sum_base + in_data.data_byte;

    q_cmd.first = !open_frame;
    q_cmd.last  = (rem_base == 16'd1);
    q_cmd.data  = in_data.data_byte;
    q_cmd.flen  = plen + 16'd2;
    q_cmd.ftype = in_data.frame_type;
    q_cmd.id    = frame_counter_r;
    q_cmd.csum  = afe_pkg::CSUM_BASE - sum_new;

    frame_counter_nxt   = frame_counter_r;
    bytes_remaining_nxt = bytes_remaining_r;
    running_sum_nxt     = running_sum_r;
    if (q_push) begin
      if (!open_frame) begin
        // The id skips zero when it wraps.
        frame_counter_nxt = (frame_counter_r == 8'hFF) ? 8'd1 : frame_counter_r + 8'd1;
      end
      bytes_remaining_nxt = rem_base - 16'd1;
      running_sum_nxt     = q_cmd.last ? 8'd0 : sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_counter_r   <= 8'd1;
      bytes_remaining_r <= '0;
      running_sum_r     <= '0;
    end else begin
      frame_counter_r   <= frame_counter_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
      running_sum_r     <= running_sum_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/afe_back.sv
// ----------------------------------------------------------------------------
// API frame encoder back
// Expands each queued command into its frame bytes into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module afe_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire afe_pkg::cmd_t  q_cmd,
  output logic                q_pop,
  output logic                out_empty,
  input  wire logic           out_pop,
  output afe_pkg::out_t       out_data
);

  localparam logic [2:0] ST_HEAD = 3'd0;
  localparam logic [2:0] ST_LENH = 3'd1;
  localparam logic [2:0] ST_LENL = 3'd2;
  localparam logic [2:0] ST_TYPE = 3'd3;
  localparam logic [2:0] ST_ID   = 3'd4;
  localparam logic [2:0] ST_DATA = 3'd5;
  localparam logic [2:0] ST_CSUM = 3'd6;

  logic [2:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  afe_pkg::out_t out_r;
  afe_pkg::out_t emit;
  logic          load, fire;

  assign load      = !out_valid_r || out_pop;
  assign fire      = load && q_valid;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    emit.out_byte  = q_cmd.data;
    emit.frame_end = 1'b0;
    step_nxt       = step_r;
    q_pop          = 1'b0;
    unique case (step_r)
      ST_HEAD: begin
        if (q_cmd.first) begin
          emit.out_byte = afe_pkg::DELIM_BYTE;
          step_nxt      = ST_LENH;
        end else if (q_cmd.last) begin
          step_nxt = ST_CSUM;
        end else begin
          q_pop = fire;
        end
      end
      ST_LENH: begin
        emit.out_byte = q_cmd.flen[15:8];
        step_nxt      = ST_LENL;
      end
      ST_LENL: begin
        emit.out_byte = q_cmd.flen[7:0];
        step_nxt      = ST_TYPE;
      end
      ST_TYPE: begin
        emit.out_byte = q_cmd.ftype;
        step_nxt      = ST_ID;
      end
      ST_ID: begin
        emit.out_byte = q_cmd.id;
        step_nxt      = ST_DATA;
      end
      ST_DATA: begin
        if (q_cmd.last) begin
          step_nxt = ST_CSUM;
        end else begin
          step_nxt = ST_HEAD;
          q_pop    = fire;
        end
      end
      ST_CSUM: begin
        emit.out_byte  = q_cmd.csum;
        emit.frame_end = 1'b1;
        step_nxt       = ST_HEAD;
        q_pop          = fire;
      end
      default: begin
        step_nxt = ST_HEAD;
      end
    endcase
    if (!fire) begin
      step_nxt = step_r;
    end
    out_valid_nxt = fire || (out_valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= emit;
    end
  end

`ifndef SYNTHESIS
  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && load)
    else $error("command popped without a head or a free output register");

  a_mid_command_head: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != ST_HEAD |-> q_valid)
    else $error("serializer is inside a command but the queue is empty");

  a_end_returns_head: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit.frame_end |=> step_r == ST_HEAD)
    else $error("checksum word did not return the serializer to the head");

  a_end_pops: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit.frame_end |-> q_pop)
    else $error("checksum word did not retire its command");
`endif

endmodule

`default_nettype wire

### sv/api_frame_encoder.sv
// A pushed word is registered in the command queue and then in the output register.
// A middle payload word gives its data byte; a frame's first word gives the delimiter,
// length high and low, type, id, data and, in a one-byte frame, the checksum; the last
// word gives data then checksum. One byte leaves per cycle while the output can load.
// Reset (synchronous, rst_n low) empties the queue and output register, closes any frame
// and sets the next frame id to 1.
// ----------------------------------------------------------------------------
// API frame encoder
// Wraps runs of payload bytes into API transmit frames with length, id and checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module api_frame_encoder #(
  parameter int QUEUE_DEPTH = afe_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire afe_pkg::in_t  in_data,
  output logic               out_empty,
  input  wire logic          out_pop,
  output afe_pkg::out_t      out_data
);

  logic          q_push, q_pop, q_valid;
  afe_pkg::cmd_t q_wcmd;
  logic [$bits(afe_pkg::cmd_t)-1:0] q_rdata;

  afe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (in_full),
    .q_push  (q_push),
    .q_cmd   (q_wcmd)
  );

  afe_fifo #(
    .WIDTH ($bits(afe_pkg::cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wcmd),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  afe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (afe_pkg::cmd_t'(q_rdata)),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
